### design/gxb_pkg.sv
// gxb_pkg: shared types, codes and helpers of the gf2 xor basis insert block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package gxb_pkg;

  localparam int ROWS_PER_SAMPLE = 64;
  localparam int PIV_W           = 6;
  localparam int SMALL_BITS      = 4;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    ST_STORED    = 2'd0,
    ST_DEPENDENT = 2'd1,
    ST_CONFLICT  = 2'd2,
    ST_CLEARED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_REDUCE = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_REPLY  = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_SWEEP = 2'd0,
    BK_IDLE  = 2'd1,
    BK_RUN   = 2'd2
  } back_state_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    status_t                   status;
    logic [SMALL_BITS-1:0]     residual;
    logic [PIV_W-1:0]          pivot;
  } cmd_ctl_t;

  function automatic logic [PIV_W-1:0] top_bit(input logic [63:0] v);
    logic [PIV_W-1:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        p = PIV_W'(i);
      end
    end
    return p;
  endfunction

endpackage

### design/gxb_front.sv
// gxb_front: accepts input words, classifies them and holds one command
// depends on gxb_pkg
`timescale 1ns / 1ps

module gxb_front import gxb_pkg::*; #(
  parameter int SAMPLES   = 64,
  parameter int ROW_WIDTH = 64,
  parameter int SAW       = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 init_done,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [5:0]           in_sample,
  input  logic [63:0]          in_vector,
  input  logic [5:0]           in_row_to_clear,
  output logic                 push_valid,
  input  logic                 push_ready,
  output cmd_ctl_t             push_ctl,
  output logic [SAW-1:0]       push_sample,
  output logic [ROW_WIDTH-1:0] push_vector
);

  localparam int SXW = (SAW > 6) ? SAW : 6;

  logic                 fr_v_r, fr_v_nxt;
  cmd_ctl_t             fr_ctl_r, ctl_nxt;
  logic [SAW-1:0]       fr_samp_r;
  logic [ROW_WIDTH-1:0] fr_vec_r;

  logic                 sample_ok, row_ok, low_vec, accept;
  logic [ROW_WIDTH-1:0] vec_m;
  logic [SXW-1:0]       sample_x;

  assign vec_m     = in_vector[ROW_WIDTH-1:0];
  assign sample_x  = SXW'(in_sample);
  assign sample_ok = (32'(in_sample) < 32'(SAMPLES));
  assign row_ok    = (32'(in_row_to_clear) < 32'(ROW_WIDTH));
  assign low_vec   = (vec_m[ROW_WIDTH-1:SMALL_BITS] == '0);

  assign in_ready = init_done && (!fr_v_r || push_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    ctl_nxt.kind     = CMD_REPLY;
    ctl_nxt.status   = ST_CLEARED;
    ctl_nxt.residual = '0;
    ctl_nxt.pivot    = '0;
    if (in_mode == MODE_CLEAR) begin
      ctl_nxt.pivot = in_row_to_clear;
      if (sample_ok && row_ok) begin
        ctl_nxt.kind = CMD_CLEAR;
      end
    end else if (!sample_ok) begin
      ctl_nxt.status = ST_CONFLICT;
    end else if (low_vec) begin
      ctl_nxt.status   = (vec_m == '0) ? ST_DEPENDENT : ST_CONFLICT;
      ctl_nxt.residual = vec_m[SMALL_BITS-1:0];
    end else begin
      ctl_nxt.kind  = CMD_REDUCE;
      ctl_nxt.pivot = top_bit(64'(vec_m));
    end
  end

  always_comb begin
    fr_v_nxt = fr_v_r;
    if (accept) begin
      fr_v_nxt = 1'b1;
    end else if (push_ready) begin
      fr_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else begin
      fr_v_r <= fr_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_ctl_r  <= ctl_nxt;
      fr_samp_r <= sample_x[SAW-1:0];
      fr_vec_r  <= vec_m;
    end
  end

  assign push_valid  = fr_v_r;
  assign push_ctl    = fr_ctl_r;
  assign push_sample = fr_samp_r;
  assign push_vector = fr_vec_r;

endmodule

### design/gxb_queue.sv
// gxb_queue: short command queue between the front and the back
// depends on gxb_pkg
`timescale 1ns / 1ps

module gxb_queue import gxb_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != CW'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

### design/gxb_back.sv
// gxb_back: basis memory, reduction sequencer and result register
// depends on gxb_pkg
`timescale 1ns / 1ps

module gxb_back import gxb_pkg::*; #(
  parameter int SAMPLES   = 64,
  parameter int ROW_WIDTH = 64,
  parameter int SAW       = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  output logic                 init_done,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  cmd_ctl_t             cmd_ctl,
  input  logic [SAW-1:0]       cmd_sample,
  input  logic [ROW_WIDTH-1:0] cmd_vector,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [5:0]           out_stored_row,
  output logic [3:0]           out_residual
);

  localparam int DEPTH = SAMPLES * ROWS_PER_SAMPLE;
  localparam int AW    = SAW + PIV_W;

  logic [ROW_WIDTH-1:0] basis_r [DEPTH];
  logic [ROW_WIDTH-1:0] rd_data_r;

  back_state_t          state_r, state_nxt;
  logic [AW-1:0]        sweep_r, sweep_nxt;
  logic [ROW_WIDTH-1:0] v_r, v_nxt;
  logic [SAW-1:0]       samp_r, samp_nxt;
  logic [PIV_W-1:0]     piv_r, piv_nxt;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r;
  logic [PIV_W-1:0]      out_row_r;
  logic [SMALL_BITS-1:0] out_res_r;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_wa, mem_ra;
  logic [ROW_WIDTH-1:0]  mem_wd, vx;
  logic                  fire, res_load;
  status_t               res_status;
  logic [PIV_W-1:0]      res_row;
  logic [SMALL_BITS-1:0] res_res;

  assign vx        = v_r ^ rd_data_r;
  assign fire      = cmd_valid && cmd_ready;
  assign init_done = (state_r != BK_SWEEP);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_SWEEP: begin
        if (sweep_r == AW'(DEPTH - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (fire && cmd_ctl.kind == CMD_REDUCE) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (res_load) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready  = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = sweep_r;
    mem_wd     = '0;
    mem_re     = 1'b0;
    mem_ra     = {samp_r, piv_r};
    res_load   = 1'b0;
    res_status = ST_STORED;
    res_row    = '0;
    res_res    = '0;
    v_nxt      = v_r;
    piv_nxt    = piv_r;
    samp_nxt   = samp_r;
    sweep_nxt  = sweep_r;
    unique case (state_r)
      BK_SWEEP: begin
        mem_we    = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
      end
      BK_IDLE: begin
        cmd_ready = !out_valid_r || out_ready;
        if (fire) begin
          unique case (cmd_ctl.kind)
            CMD_REDUCE: begin
              mem_re   = 1'b1;
              mem_ra   = {cmd_sample, cmd_ctl.pivot};
              v_nxt    = cmd_vector;
              piv_nxt  = cmd_ctl.pivot;
              samp_nxt = cmd_sample;
            end
            CMD_CLEAR: begin
              mem_we     = 1'b1;
              mem_wa     = {cmd_sample, cmd_ctl.pivot};
              res_load   = 1'b1;
              res_status = ST_CLEARED;
            end
            default: begin
              res_load   = 1'b1;
              res_status = cmd_ctl.status;
              res_res    = cmd_ctl.residual;
            end
          endcase
        end
      end
      BK_RUN: begin
        if (rd_data_r == '0) begin
          // empty pivot row takes the vector
          mem_we     = 1'b1;
          mem_wa     = {samp_r, piv_r};
          mem_wd     = v_r;
          res_load   = 1'b1;
          res_status = ST_STORED;
          res_row    = piv_r;
        end else if (vx[ROW_WIDTH-1:SMALL_BITS] == '0) begin
          res_load   = 1'b1;
          res_status = (vx == '0) ? ST_DEPENDENT : ST_CONFLICT;
          res_res    = vx[SMALL_BITS-1:0];
        end else begin
          v_nxt   = vx;
          piv_nxt = top_bit(64'(vx));
          mem_re  = 1'b1;
          mem_ra  = {samp_r, piv_nxt};
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_SWEEP;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    piv_r  <= piv_nxt;
    samp_r <= samp_nxt;
    if (res_load) begin
      out_status_r <= res_status;
      out_row_r    <= res_row;
      out_res_r    <= res_res;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      basis_r[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= basis_r[mem_ra];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_stored_row = out_row_r;
  assign out_residual   = out_res_r;

endmodule

### design/gf2_xor_basis_insert.sv
// Keeps one GF(2) row-echelon basis per sample and inserts or clears rows.
// An insert word is classified at the front and queued; the back then walks
// the basis one pivot row per cycle (memory read, XOR, next pivot); clears and
// words answered at the front are settled by the back without such a walk.
// After reset a clearing pass over all SAMPLES*64 basis rows zeroes the
// memory while in_ready stays low. Results leave through a register, so the
// next word is taken while a result waits.
// top level; depends on gxb_pkg, gxb_front, gxb_queue, gxb_back
`timescale 1ns / 1ps

module gf2_xor_basis_insert import gxb_pkg::*; #(
  parameter int SAMPLES   = 64,
  parameter int ROW_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [5:0]  in_sample,
  input  logic [63:0] in_vector,
  input  logic [5:0]  in_row_to_clear,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [5:0]  out_stored_row,
  output logic [3:0]  out_residual
);

  localparam int SAW   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int CTL_W = $bits(cmd_ctl_t);
  localparam int QW    = CTL_W + SAW + ROW_WIDTH;

  logic                 init_done;
  logic                 push_valid, push_ready, pop_valid, pop_ready;
  cmd_ctl_t             push_ctl, pop_ctl;
  logic [SAW-1:0]       push_sample, pop_sample;
  logic [ROW_WIDTH-1:0] push_vector, pop_vector;
  logic [QW-1:0]        push_data, pop_data;

  gxb_front #(
    .SAMPLES   (SAMPLES),
    .ROW_WIDTH (ROW_WIDTH),
    .SAW       (SAW)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .init_done       (init_done),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_sample       (in_sample),
    .in_vector       (in_vector),
    .in_row_to_clear (in_row_to_clear),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_ctl        (push_ctl),
    .push_sample     (push_sample),
    .push_vector     (push_vector)
  );

  assign push_data = {push_ctl, push_sample, push_vector};

  gxb_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_ctl    = cmd_ctl_t'(pop_data[QW-1 -: CTL_W]);
  assign pop_sample = pop_data[ROW_WIDTH +: SAW];
  assign pop_vector = pop_data[ROW_WIDTH-1:0];

  gxb_back #(
    .SAMPLES   (SAMPLES),
    .ROW_WIDTH (ROW_WIDTH),
    .SAW       (SAW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .init_done      (init_done),
    .cmd_valid      (pop_valid),
    .cmd_ready      (pop_ready),
    .cmd_ctl        (pop_ctl),
    .cmd_sample     (pop_sample),
    .cmd_vector     (pop_vector),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_stored_row (out_stored_row),
    .out_residual   (out_residual)
  );

endmodule

### design/gxb_checker.sv
// gxb_checker: port-level assertions for gf2_xor_basis_insert, bound to it
// depends on gxb_pkg and the top level's ports
`timescale 1ns / 1ps

module gxb_checker import gxb_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [5:0] out_stored_row,
  input logic [3:0] out_residual
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("output or input side active right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_stored_row) && $stable(out_residual))
    else $error("stalled result word changed");

  a_row_only_on_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != 2'(ST_STORED) |-> out_stored_row == 6'd0)
    else $error("stored row reported without a store");

  a_residual_only_on_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != 2'(ST_CONFLICT) |-> out_residual == 4'd0)
    else $error("residual reported without a conflict");

endmodule

bind gf2_xor_basis_insert gxb_checker u_gxb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_stored_row (out_stored_row),
  .out_residual   (out_residual)
);
